/* rtl/kstoa_pkg.sv */
package kstoa_pkg;

   localparam logic [7:0] CODE_CTRL_PRESS    = 8'h1D;
   localparam logic [7:0] CODE_LSHIFT_PRESS  = 8'h2A;
   localparam logic [7:0] CODE_RSHIFT_PRESS  = 8'h36;
   localparam logic [7:0] CODE_CAPS_TOGGLE   = 8'h3A;
   localparam logic [7:0] CODE_CTRL_RELEASE  = 8'h9D;
   localparam logic [7:0] CODE_LSHIFT_RELEASE = 8'hAA;
   localparam logic [7:0] CODE_RSHIFT_RELEASE = 8'hB6;

   localparam logic [7:0] ROM_DEPTH   = 8'd59;
   localparam logic [7:0] CASE_OFFSET = 8'h20;
   localparam logic [7:0] CHAR_LOW_A  = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;

   localparam logic       CSR_KILL_KEY = 1'b0;
   localparam logic       CSR_EOF_KEY  = 1'b1;

   localparam logic [7:0] KILL_KEY_RESET = 8'd99;
   localparam logic [7:0] EOF_KEY_RESET  = 8'd100;

   typedef struct packed {
      logic ctrl;
      logic left_shift;
      logic right_shift;
      logic caps;
   } kstoa_mods_type;

   function automatic logic [7:0] lower_rom(input logic [5:0] idx);
      logic [7:0] ch;
      case (idx)
         6'd1:  ch = 8'h1B;
         6'd2:  ch = 8'h31;
         6'd3:  ch = 8'h32;
         6'd4:  ch = 8'h33;
         6'd5:  ch = 8'h34;
         6'd6:  ch = 8'h35;
         6'd7:  ch = 8'h36;
         6'd8:  ch = 8'h37;
         6'd9:  ch = 8'h38;
         6'd10: ch = 8'h39;
         6'd11: ch = 8'h30;
         6'd12: ch = 8'h27;
         6'd14: ch = 8'h08;
         6'd15: ch = 8'h09;
         6'd16: ch = 8'h71;
         6'd17: ch = 8'h77;
         6'd18: ch = 8'h65;
         6'd19: ch = 8'h72;
         6'd20: ch = 8'h74;
         6'd21: ch = 8'h79;
         6'd22: ch = 8'h75;
         6'd23: ch = 8'h69;
         6'd24: ch = 8'h6F;
         6'd25: ch = 8'h70;
         6'd27: ch = 8'h2B;
         6'd28: ch = 8'h0A;
         6'd30: ch = 8'h61;
         6'd31: ch = 8'h73;
         6'd32: ch = 8'h64;
         6'd33: ch = 8'h66;
         6'd34: ch = 8'h67;
         6'd35: ch = 8'h68;
         6'd36: ch = 8'h6A;
         6'd37: ch = 8'h6B;
         6'd38: ch = 8'h6C;
         6'd40: ch = 8'h7B;
         6'd41: ch = 8'h7C;
         6'd43: ch = 8'h7D;
         6'd44: ch = 8'h7A;
         6'd45: ch = 8'h78;
         6'd46: ch = 8'h63;
         6'd47: ch = 8'h76;
         6'd48: ch = 8'h62;
         6'd49: ch = 8'h6E;
         6'd50: ch = 8'h6D;
         6'd51: ch = 8'h2C;
         6'd52: ch = 8'h2E;
         6'd53: ch = 8'h2D;
         6'd57: ch = 8'h20;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] upper_rom(input logic [5:0] idx);
      logic [7:0] low;
      logic [7:0] ch;
      low = lower_rom(idx);
      case (idx)
         6'd2:  ch = 8'h21;
         6'd3:  ch = 8'h22;
         6'd4:  ch = 8'h23;
         6'd5:  ch = 8'h24;
         6'd6:  ch = 8'h25;
         6'd7:  ch = 8'h26;
         6'd8:  ch = 8'h2F;
         6'd9:  ch = 8'h28;
         6'd10: ch = 8'h29;
         6'd11: ch = 8'h3D;
         6'd12: ch = 8'h3F;
         6'd27: ch = 8'h2A;
         6'd40: ch = 8'h5B;
         6'd41: ch = 8'h00;
         6'd43: ch = 8'h5D;
         6'd51: ch = 8'h3B;
         6'd52: ch = 8'h3A;
         6'd53: ch = 8'h5F;
         default: begin
            if (low >= CHAR_LOW_A && low <= CHAR_LOW_Z) begin
               ch = low - CASE_OFFSET;
            end else begin
               ch = low;
            end
         end
      endcase
      return ch;
   endfunction

endpackage

/* rtl/kstoa_if.sv */
interface kstoa_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] scan_code;
   logic       buffer_full;

   modport source (output valid, output scan_code, output buffer_full, input ready);
   modport sink   (input valid, input scan_code, input buffer_full, output ready);
endinterface

interface kstoa_rsp_if;
   logic       valid;
   logic       ready;
   logic       write_enable;
   logic [7:0] char_out;
   logic       kill_request;
   logic       eof_request;

   modport source (output valid, output write_enable, output char_out,
                   output kill_request, output eof_request, input ready);
   modport sink   (input valid, input write_enable, input char_out,
                   input kill_request, input eof_request, output ready);
endinterface

/* rtl/keyboard_scancode_to_ascii.sv */
// Set-1 keyboard scan code translator for a Spanish layout.
// The req channel carries one scan code and the buffer-full flag per item;
// the rsp channel returns exactly one result item for each request item:
// a write enable, the character, and kill and end-of-file request flags.
// Both channels use valid/ready; an item moves when both are high.
// A request item is first captured in an input register, then translated
// by the ROM lookup and modifier logic into the result register.
// Throughput is one item per cycle; the two registers form a pipeline
// that advances whenever the result register is empty or being taken.
// When the receiver stalls, the result register holds its item and the
// input register fills; req.ready then drops until rsp.ready returns.
// The ctrl, shift and caps-lock flags change as an item enters the result
// register, so a modifier affects every later item.
// The csr port writes the kill key (index 0) or the end-of-file key
// (index 1). Synchronous reset empties both registers, clears all
// modifier flags and restores the key registers to 'c' and 'd'.
module keyboard_scancode_to_ascii (
   input  logic                clock,
   input  logic                reset,
   kstoa_req_if.sink           req,
   kstoa_rsp_if.source         rsp,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [7:0]          csr_write_data
);
   import kstoa_pkg::*;

   logic           in_valid_ff;
   logic [7:0]     in_code_ff;
   logic           in_full_ff;
   logic           out_valid_ff;
   logic           out_we_ff;
   logic [7:0]     out_char_ff;
   logic           out_kill_ff;
   logic           out_eof_ff;
   kstoa_mods_type mods_ff;
   kstoa_mods_type mods_in;
   logic [7:0]     kill_key_ff;
   logic [7:0]     eof_key_ff;

   logic           out_free;
   logic           advance;
   logic           is_modifier;
   logic [7:0]     rom_char;
   logic [7:0]     char_code;
   logic           kill_hit;
   logic           eof_hit;
   logic           we_in;
   logic [7:0]     char_in;
   logic           kill_in;
   logic           eof_in;

   assign out_free  = !out_valid_ff || rsp.ready;
   assign advance   = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;

   kstoa_lookup u_lookup (
      .scan_code (in_code_ff),
      .mods      (mods_ff),
      .char_code (rom_char)
   );

   always_comb begin
      mods_in     = mods_ff;
      is_modifier = 1'b1;
      case (in_code_ff)
         CODE_CTRL_PRESS:     mods_in.ctrl        = 1'b1;
         CODE_LSHIFT_PRESS:   mods_in.left_shift  = 1'b1;
         CODE_RSHIFT_PRESS:   mods_in.right_shift = 1'b1;
         CODE_CAPS_TOGGLE:    mods_in.caps        = !mods_ff.caps;
         CODE_CTRL_RELEASE:   mods_in.ctrl        = 1'b0;
         CODE_LSHIFT_RELEASE: mods_in.left_shift  = 1'b0;
         CODE_RSHIFT_RELEASE: mods_in.right_shift = 1'b0;
         default:             is_modifier         = 1'b0;
      endcase
   end

   always_comb begin
      char_code = is_modifier ? 8'h00 : rom_char;
      kill_hit  = (char_code == kill_key_ff) ||
                  ((kill_key_ff >= CASE_OFFSET) && (char_code == kill_key_ff - CASE_OFFSET));
      eof_hit   = (char_code == eof_key_ff) ||
                  ((eof_key_ff >= CASE_OFFSET) && (char_code == eof_key_ff - CASE_OFFSET));
      we_in     = 1'b0;
      char_in   = 8'h00;
      kill_in   = 1'b0;
      eof_in    = 1'b0;
      if (mods_in.ctrl) begin
         if (kill_hit) begin
            we_in   = 1'b1;
            kill_in = 1'b1;
         end else if (eof_hit) begin
            we_in  = 1'b1;
            eof_in = 1'b1;
         end
      end else if (char_code != 8'h00 && !in_full_ff) begin
         we_in   = 1'b1;
         char_in = char_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mods_ff      <= '0;
         kill_key_ff  <= KILL_KEY_RESET;
         eof_key_ff   <= EOF_KEY_RESET;
      end else begin
         if (req.valid && req.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            mods_ff      <= mods_in;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_KILL_KEY: kill_key_ff <= csr_write_data;
               CSR_EOF_KEY:  eof_key_ff  <= csr_write_data;
               default:      kill_key_ff <= kill_key_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_code_ff <= req.scan_code;
         in_full_ff <= req.buffer_full;
      end
      if (advance) begin
         out_we_ff   <= we_in;
         out_char_ff <= char_in;
         out_kill_ff <= kill_in;
         out_eof_ff  <= eof_in;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.write_enable = out_we_ff;
   assign rsp.char_out     = out_char_ff;
   assign rsp.kill_request = out_kill_ff;
   assign rsp.eof_request  = out_eof_ff;

endmodule

/* rtl/kstoa_lookup.sv */
module kstoa_lookup (
   input  logic [7:0]              scan_code,
   input  kstoa_pkg::kstoa_mods_type mods,
   output logic [7:0]              char_code
);
   import kstoa_pkg::*;

   logic [7:0] low_ch;
   logic [7:0] up_ch;
   logic       shift;
   logic       letter;

   always_comb begin
      low_ch = lower_rom(scan_code[5:0]);
      up_ch  = upper_rom(scan_code[5:0]);
      shift  = mods.left_shift | mods.right_shift;
      letter = (low_ch >= CHAR_LOW_A) && (low_ch <= CHAR_LOW_Z);
      if (scan_code >= ROM_DEPTH) begin
         char_code = 8'h00;
      end else if (shift || (mods.caps && letter)) begin
         char_code = up_ch;
      end else begin
         char_code = low_ch;
      end
   end

endmodule
